// File: rtl/core/lbta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbta_pkg
// Shared widths, defaults and operation codes for the linked block table
// allocator.
// ----------------------------------------------------------------------------
package lbta_pkg;

  localparam int LINK_W               = 10;
  localparam int MAX_TBL_DEPTH        = 1 << LINK_W;
  localparam int NUM_BLOCKS_DEF       = 1024;
  localparam int FIRST_DATA_BLOCK_DEF = 32;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_TRUNC = 2'd2;
  localparam logic [1:0] OP_NEXT  = 2'd3;

endpackage

// File: rtl/core/linked_block_table_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_block_table_allocator
// Next-pointer table that holds both the free list and the file block
// chains: alloc, free chain, truncate after block and link lookup.
//
//   channel | direction | payload (low bit first)
//   in_     | slave     | op[1:0], block[11:2], prev_block[21:12]
//   out_    | master    | status[0], block_out[10:1]
//
// After reset the table is filled one entry a cycle (TBL_DEPTH entries,
// 1024 by default) with in_tready low. One table RAM with registered read
// data does all work; free chain and truncate walk the freed chain block
// by block to hook it onto the free list, and alloc on an empty free
// list answers with status set.
// A held result stalls the sequencer in its last step until taken.
// ----------------------------------------------------------------------------
module linked_block_table_allocator
  import lbta_pkg::*;
#(
  parameter int NUM_BLOCKS       = NUM_BLOCKS_DEF,
  parameter int FIRST_DATA_BLOCK = FIRST_DATA_BLOCK_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // op[1:0], block[11:2], prev_block[21:12]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // status[0], block_out[10:1]
);

  localparam int TBL_DEPTH = (NUM_BLOCKS < MAX_TBL_DEPTH) ? NUM_BLOCKS : MAX_TBL_DEPTH;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int STEP_W    = $clog2(NUM_BLOCKS + 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOOK = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_LINK = 3'd4;
  localparam logic [2:0] S_CUT  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic in_range(input logic [LINK_W-1:0] b);
    return 32'(b) < 32'(NUM_BLOCKS);
  endfunction

  logic [LINK_W-1:0] mem [TBL_DEPTH];
  logic [LINK_W-1:0] rd_data_r;

  logic [2:0]              state_r, state_nxt;
  logic [1:0]              op_r, op_nxt;
  logic [LINK_W-1:0]       blk_r, blk_nxt;
  logic [LINK_W-1:0]       prev_r, prev_nxt;
  logic [LINK_W-1:0]       cur_r, cur_nxt;
  logic [LINK_W-1:0]       old_head_r, old_head_nxt;
  logic [LINK_W-1:0]       free_head_r, free_head_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  logic [IDX_W-1:0]        init_cnt_r, init_cnt_nxt;
  logic                    res_status_r, res_status_nxt;
  logic [LINK_W-1:0]       res_block_r, res_block_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic [LINK_W-1:0]       mem_wd;
  logic [IDX_W-1:0]        mem_ra;

  logic [1:0]              in_op;
  logic [LINK_W-1:0]       in_block;
  logic [LINK_W-1:0]       in_prev;
  logic                    walk_stop;

  assign in_op    = in_tdata[1:0];
  assign in_block = in_tdata[2 +: LINK_W];
  assign in_prev  = in_tdata[2 + LINK_W +: LINK_W];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign walk_stop = (rd_data_r == '0) || !in_range(rd_data_r) ||
                     (32'(steps_r) >= 32'(NUM_BLOCKS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    old_head_nxt   = old_head_r;
    free_head_nxt  = free_head_r;
    steps_nxt      = steps_r;
    init_cnt_nxt   = init_cnt_r;
    res_status_nxt = res_status_r;
    res_block_nxt  = res_block_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_ra         = '0;

    // drop the result once the sink takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = init_cnt_r;
        mem_wd = (32'(init_cnt_r) == TBL_DEPTH - 1) ? '0 :
                 LINK_W'(32'(init_cnt_r) + 32'd1);
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (32'(init_cnt_r) == TBL_DEPTH - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_op;
          blk_nxt        = in_block;
          prev_nxt       = in_prev;
          res_status_nxt = 1'b0;
          res_block_nxt  = '0;
          state_nxt      = S_DONE;
          unique case (in_op)
            OP_ALLOC: begin
              if (free_head_r == '0 || !in_range(free_head_r)) begin
                res_status_nxt = 1'b1;
              end else begin
                cur_nxt   = free_head_r;
                mem_ra    = free_head_r[IDX_W-1:0];
                state_nxt = S_LOOK;
              end
            end
            OP_FREE: begin
              if (in_block != '0 && in_range(in_block)) begin
                old_head_nxt  = free_head_r;
                free_head_nxt = in_block;
                cur_nxt       = in_block;
                steps_nxt     = '0;
                mem_ra        = in_block[IDX_W-1:0];
                state_nxt     = S_WALK;
              end
            end
            OP_TRUNC: begin
              if (in_block != '0 && in_range(in_block)) begin
                mem_ra    = in_block[IDX_W-1:0];
                state_nxt = S_LOOK;
              end
            end
            OP_NEXT: begin
              if (in_range(in_block)) begin
                mem_ra    = in_block[IDX_W-1:0];
                state_nxt = S_LOOK;
              end
            end
          endcase
        end
      end
      S_LOOK: begin
        unique case (op_r)
          OP_ALLOC: begin
            free_head_nxt = rd_data_r;
            mem_we        = 1'b1;
            mem_wa        = cur_r[IDX_W-1:0];
            mem_wd        = '0;
            res_block_nxt = cur_r;
            state_nxt     = (prev_r != '0 && in_range(prev_r)) ? S_LINK : S_DONE;
          end
          OP_TRUNC: begin
            if (rd_data_r != '0 && in_range(rd_data_r)) begin
              old_head_nxt  = free_head_r;
              free_head_nxt = rd_data_r;
              cur_nxt       = rd_data_r;
              steps_nxt     = '0;
              mem_ra        = rd_data_r[IDX_W-1:0];
              state_nxt     = S_WALK;
            end else begin
              state_nxt = S_CUT;
            end
          end
          OP_NEXT: begin
            res_block_nxt = rd_data_r;
            state_nxt     = S_DONE;
          end
          OP_FREE: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_WALK: begin
        if (walk_stop) begin
          // hook the tail onto the old free list
          mem_we    = 1'b1;
          mem_wa    = cur_r[IDX_W-1:0];
          mem_wd    = old_head_r;
          state_nxt = (op_r == OP_TRUNC) ? S_CUT : S_DONE;
        end else begin
          cur_nxt   = rd_data_r;
          steps_nxt = steps_r + 1'b1;
          mem_ra    = rd_data_r[IDX_W-1:0];
        end
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wa    = prev_r[IDX_W-1:0];
        mem_wd    = cur_r;
        state_nxt = S_DONE;
      end
      S_CUT: begin
        mem_we    = 1'b1;
        mem_wa    = blk_r[IDX_W-1:0];
        mem_wd    = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({res_block_r, res_status_r});
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      free_head_r  <= LINK_W'(FIRST_DATA_BLOCK);
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      free_head_r  <= free_head_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    blk_r        <= blk_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    old_head_r   <= old_head_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_block_r  <= res_block_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice without finishing an operation");

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && (state_r == S_IDLE || state_r == S_DONE)))
    else $error("table written outside an operation");

  a_head_stable_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> $stable(free_head_r))
    else $error("free head moved while result pending");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> 32'(steps_r) <= 32'(NUM_BLOCKS))
    else $error("chain walk ran past the block count");

  a_result_only_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the done step");

endmodule
